### rtl/tpm_pkg.sv
// Shared constants, coefficient table and control types for the 4x true-peak meter.
// No dependencies; every other file imports this package.
package tpm_pkg;

   localparam int TAPS        = 12;
   localparam int PHASES      = 4;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 14;
   localparam int COEF_FRAC   = 13;
   localparam int SUM_BITS    = $clog2(TAPS);
   localparam int TREE_LEVELS = $clog2(TAPS);
   localparam int TREE_WIDTH  = 1 << TREE_LEVELS;

   localparam logic signed [COEF_BITS-1:0] COEF_TAB [PHASES][TAPS] = '{
      '{ 14'sd14,    14'sd90,   -14'sd161,  14'sd272,  -14'sd487,  14'sd1125,
         14'sd7964, -14'sd838,   14'sd390, -14'sd218,   14'sd122, -14'sd68 },
      '{-14'sd239,   14'sd240,  -14'sd424,  14'sd730,  -14'sd1364, 14'sd3810,
         14'sd6388, -14'sd1641,  14'sd832, -14'sd477,   14'sd271, -14'sd155 },
      '{-14'sd155,   14'sd271,  -14'sd477,  14'sd832,  -14'sd1641, 14'sd6388,
         14'sd3810, -14'sd1364,  14'sd730, -14'sd424,   14'sd240, -14'sd239 },
      '{-14'sd68,    14'sd122,  -14'sd218,  14'sd390,  -14'sd838,  14'sd7964,
         14'sd1125, -14'sd487,   14'sd272, -14'sd161,   14'sd90,   14'sd14 }
   };

   typedef struct packed {
      logic accept;
      logic load;
   } tpm_ctrl_type;

endpackage

### rtl/tpm_channels.sv
// Valid/ready channel interfaces for sample items and peak result items.
// Depends on tpm_pkg for the default sample width.
interface tpm_req_if
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface tpm_rsp_if
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS:0]   true_peak;

   modport source (output valid, output true_peak, input ready);
   modport sink   (input valid, input true_peak, output ready);
endinterface

### rtl/tpm_history.sv
// Sample history line, newest entry first, plus the flag for an item not yet filtered.
// Depends on tpm_pkg for TAPS and the control struct.
module tpm_history
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpm_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] hist [TAPS],
   output logic                          hist_valid
);

   logic signed [SAMPLE_BITS-1:0] hist_ff [TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_in [TAPS];
   logic                          valid_ff;
   logic                          valid_in;

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.accept) begin
         hist_in[0] = sample_in;
         for (int k = 1; k < TAPS; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.accept) begin
         valid_in = 1'b1;
      end else if (ctrl.load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k < TAPS; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         hist_ff  <= hist_in;
      end
   end

   assign hist       = hist_ff;
   assign hist_valid = valid_ff;

endmodule

### rtl/tpm_fir.sv
// Polyphase FIR bank: per-phase constant products, adder tree, magnitude and rounding.
// Depends on tpm_pkg for the coefficient table and tree sizes.
module tpm_fir
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS,
   parameter int ACC_BITS    = SAMPLE_BITS + COEF_BITS + SUM_BITS,
   parameter int MAG_BITS    = ACC_BITS + 1 - COEF_FRAC
) (
   input  logic signed [SAMPLE_BITS-1:0] hist [TAPS],
   output logic        [MAG_BITS-1:0]    phase_mag [PHASES]
);

   logic signed [ACC_BITS-1:0] node [PHASES][TREE_LEVELS+1][TREE_WIDTH];
   logic signed [ACC_BITS-1:0] acc  [PHASES];
   logic        [ACC_BITS-1:0] mag  [PHASES];
   logic        [ACC_BITS:0]   rnd  [PHASES];

   always_comb begin
      for (int p = 0; p < PHASES; p++) begin
         for (int l = 0; l <= TREE_LEVELS; l++) begin
            for (int i = 0; i < TREE_WIDTH; i++) begin
               node[p][l][i] = '0;
            end
         end
         for (int k = 0; k < TAPS; k++) begin
            node[p][0][k] = ACC_BITS'(hist[k]) * ACC_BITS'(COEF_TAB[p][k]);
         end
         for (int l = 0; l < TREE_LEVELS; l++) begin
            for (int i = 0; i < (TREE_WIDTH >> (l + 1)); i++) begin
               node[p][l+1][i] = node[p][l][2*i] + node[p][l][2*i+1];
            end
         end
         acc[p] = node[p][TREE_LEVELS][0];
         mag[p] = acc[p][ACC_BITS-1] ? ACC_BITS'(-acc[p]) : ACC_BITS'(acc[p]);
         rnd[p] = {1'b0, mag[p]} + ((ACC_BITS+1)'(1) << (COEF_FRAC - 1));
         phase_mag[p] = rnd[p][ACC_BITS:COEF_FRAC];
      end
   end

endmodule

### rtl/tpm_peak_reg.sv
// Phase maximum, saturation to the output range and the result register.
// Depends on tpm_pkg for PHASES and the control struct.
module tpm_peak_reg
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS,
   parameter int MAG_BITS    = SAMPLE_BITS + COEF_BITS + SUM_BITS + 1 - COEF_FRAC
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tpm_ctrl_type          ctrl,
   input  logic [MAG_BITS-1:0]   phase_mag [PHASES],
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic [SAMPLE_BITS:0]  true_peak
);

   localparam logic [MAG_BITS-1:0] LIMIT = MAG_BITS'({(SAMPLE_BITS+1){1'b1}});

   logic [MAG_BITS-1:0]  best;
   logic [SAMPLE_BITS:0] peak_in;
   logic [SAMPLE_BITS:0] peak_ff;
   logic                 valid_in;
   logic                 valid_ff;

   always_comb begin
      best = '0;
      for (int p = 0; p < PHASES; p++) begin
         if (phase_mag[p] > best) begin
            best = phase_mag[p];
         end
      end
      peak_in = (best > LIMIT) ? '1 : best[SAMPLE_BITS:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         peak_ff <= peak_in;
      end
   end

   assign out_valid = valid_ff;
   assign true_peak = peak_ff;

endmodule

### rtl/true_peak_meter_4x_core.sv
// Channel    Dir  Payload                        Notes
// req_if     in   sample_in   signed Q1.23       item shifts into the history line
// rsp_if     out  true_peak   unsigned Q2.23     one item per sample, saturating
//
// One sample per cycle while the result channel does not stall. The history line
// is the input register and the result register follows it; the FIR bank, maximum
// and saturation sit between the two.
// Synchronous reset clears the history to zero and empties both stages.
// A stalled result holds; one more sample is taken into the history, then
// req_if.ready drops until the result register frees.
// Depends on tpm_pkg, tpm_channels, tpm_history, tpm_fir, tpm_peak_reg.
module true_peak_meter_4x_core
   import tpm_pkg::*;
#(
   parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   tpm_req_if.sink    req_if,
   tpm_rsp_if.source  rsp_if
);

   localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + SUM_BITS;
   localparam int MAG_BITS = ACC_BITS + 1 - COEF_FRAC;

   tpm_ctrl_type                  ctrl;
   logic signed [SAMPLE_BITS-1:0] hist [TAPS];
   logic                          hist_valid;
   logic        [MAG_BITS-1:0]    phase_mag [PHASES];
   logic                          out_free;

   assign out_free     = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = !hist_valid || out_free;
   assign ctrl.accept  = req_if.valid && req_if.ready;
   assign ctrl.load    = hist_valid && out_free;

   tpm_history #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  (req_if.sample_in),
      .hist       (hist),
      .hist_valid (hist_valid)
   );

   tpm_fir #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ACC_BITS   (ACC_BITS),
      .MAG_BITS   (MAG_BITS)
   ) u_fir (
      .hist      (hist),
      .phase_mag (phase_mag)
   );

   tpm_peak_reg #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAG_BITS   (MAG_BITS)
   ) u_peak_reg (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .phase_mag (phase_mag),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .true_peak (rsp_if.true_peak)
   );

endmodule
